[sv/b64su_pkg.sv]
// ---------------------------------------------------------------------------
// b64su_pkg
// Shared types and constants of the base64 five-bit sample unpacker: the
// base64 alphabet decoder, reservoir widths and register map.
// ---------------------------------------------------------------------------
`default_nettype none

package b64su_pkg;

    localparam int unsigned CHAR_W       = 8;
    localparam int unsigned SEXTET_W     = 6;
    localparam int unsigned SEXTET_ACC_W = 12;
    localparam int unsigned SEXTET_CNT_W = 4;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned LEVEL_W      = 16;
    localparam int unsigned LEVEL_ONE    = 65536;
    localparam int unsigned LEVEL_MAX    = 65535;

    localparam int unsigned MAX_SAMPLES_RESET = 100;

    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;
    localparam logic [ADDR_W-1:0] ADDR_MAX_SAMPLES = 3'd0;

    typedef struct packed {
        logic                ok;
        logic [SEXTET_W-1:0] value;
    } sextet_t;

    function automatic sextet_t sextet_decode(input logic [CHAR_W-1:0] c);
        sextet_t r;
        logic [CHAR_W-1:0] d;
        r = '0;
        d = '0;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            d = c - 8'h41;
            r.ok = 1'b1;
            r.value = d[SEXTET_W-1:0];
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            d = c - 8'h61 + 8'd26;
            r.ok = 1'b1;
            r.value = d[SEXTET_W-1:0];
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            d = c - 8'h30 + 8'd52;
            r.ok = 1'b1;
            r.value = d[SEXTET_W-1:0];
        end
        else if (c == 8'h2B)
        begin
            r.ok = 1'b1;
            r.value = 6'd62;
        end
        else if (c == 8'h2F)
        begin
            r.ok = 1'b1;
            r.value = 6'd63;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[sv/base64_five_bit_sample_unpacker_unit.sv]
// ---------------------------------------------------------------------------
// base64_five_bit_sample_unpacker_unit
// Decodes base64 text one character per item and unpacks the byte stream,
// LSB first, into SAMPLE_BITS-bit samples with code, level, index and end
// marking. Sample count per text is capped by the max_samples register.
// ---------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  in      | in        | in_valid / in_stall  | text_char, end_of_text
//  out     | out       | out_valid / out_stall| sample_code, sample_level,
//          |           |                      | sample_index, sample_valid,
//          |           |                      | last_result
//  cfg     | in        | APB psel / penable   | max_samples at address 0
//
//  An item is registered on entry and decoded from the item register into a
//  result bank, which it loads once the bank can take its results; results leave
//  one per cycle while out_stall is low. Items that give no result never wait
//  for the bank; an item that gives k results holds the item register until the
//  bank can take them, so the rate is set by the one-result-per-cycle output port.
//  Reset clears the reservoirs, the sample count and the result bank, and sets
//  max_samples to 100.
// ---------------------------------------------------------------------------
`default_nettype none

module base64_five_bit_sample_unpacker_unit #(
    parameter int unsigned SAMPLE_BITS = 5,
    parameter int unsigned LIMIT_WIDTH = 10
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [b64su_pkg::CHAR_W-1:0]       text_char,
    input  wire logic                               end_of_text,

    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [SAMPLE_BITS-1:0]                  sample_code,
    output logic [b64su_pkg::LEVEL_W-1:0]           sample_level,
    output logic [LIMIT_WIDTH-1:0]                  sample_index,
    output logic                                    sample_valid,
    output logic                                    last_result,

    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [b64su_pkg::ADDR_W-1:0]       paddr,
    input  wire logic [b64su_pkg::DATA_W-1:0]       pwdata,
    output logic [b64su_pkg::DATA_W-1:0]            prdata,
    output logic                                    pready
);

    localparam int unsigned SB_W     = SAMPLE_BITS + b64su_pkg::BYTE_W - 1;
    localparam int unsigned SBC_W    = $clog2(SB_W + 2);
    localparam int unsigned MAX_RES  = (SAMPLE_BITS + b64su_pkg::BYTE_W - 1) / SAMPLE_BITS;
    localparam int unsigned BANK_CW  = $clog2(MAX_RES + 1);
    localparam int unsigned GIVEN_W  = LIMIT_WIDTH + 1;
    localparam int unsigned NCODES   = 1 << SAMPLE_BITS;
    localparam int unsigned CODE_DIV = NCODES - 1;
    localparam int unsigned ACC_W    = b64su_pkg::SEXTET_ACC_W;
    localparam int unsigned SCNT_W   = b64su_pkg::SEXTET_CNT_W;

    // configuration
    logic [LIMIT_WIDTH-1:0] max_samples_reg;
    logic                   cfg_write;

    // item register
    logic                          item_valid_reg;
    logic                          item_valid_next;
    logic [b64su_pkg::CHAR_W-1:0]  item_char_reg;
    logic                          item_end_reg;

    // stream state
    logic [ACC_W-1:0]       sextet_bits_reg,  sextet_bits_next;
    logic [SCNT_W-1:0]      sextet_count_reg, sextet_count_next;
    logic [SB_W-1:0]        sample_bits_reg,  sample_bits_next;
    logic [SBC_W-1:0]       sample_count_reg, sample_count_next;
    logic [LIMIT_WIDTH-1:0] given_reg,        given_next;

    // result bank
    logic [SAMPLE_BITS-1:0] bank_code_reg  [MAX_RES];
    logic [LIMIT_WIDTH-1:0] bank_index_reg [MAX_RES];
    logic                   bank_valid_reg [MAX_RES];
    logic                   bank_last_reg  [MAX_RES];
    logic [SAMPLE_BITS-1:0] bank_code_next  [MAX_RES];
    logic [LIMIT_WIDTH-1:0] bank_index_next [MAX_RES];
    logic                   bank_valid_next [MAX_RES];
    logic                   bank_last_next  [MAX_RES];
    logic [BANK_CW-1:0]     bank_cnt_reg, bank_cnt_next;

    // decode
    b64su_pkg::sextet_t     sx;
    logic [ACC_W-1:0]       acc;
    logic [SCNT_W-1:0]      cnt6;
    logic [SCNT_W-1:0]      cnt_after;
    logic                   byte_ok;
    logic [ACC_W-1:0]       acc_shift;
    logic [b64su_pkg::BYTE_W-1:0] byte_val;
    logic [SB_W-1:0]        pool;
    logic [SBC_W-1:0]       total;
    logic [SB_W-1:0]        rest_bits;
    logic [SBC_W-1:0]       rest_cnt;
    logic                   present  [MAX_RES];
    logic                   emit     [MAX_RES];
    logic [SAMPLE_BITS-1:0] new_code [MAX_RES];
    logic [LIMIT_WIDTH-1:0] new_index[MAX_RES];
    logic [GIVEN_W-1:0]     pos      [MAX_RES];
    logic [BANK_CW-1:0]     n_emit;
    logic [BANK_CW-1:0]     res_n;
    logic                   fire;
    logic                   pop;
    logic                   bank_free;
    logic                   in_accept;

    logic [b64su_pkg::LEVEL_W-1:0] level_tab [NCODES];

    for (genvar c = 0; c < NCODES; c++)
    begin : g_level
        localparam int unsigned RAW = (c * b64su_pkg::LEVEL_ONE + CODE_DIV / 2) / CODE_DIV;
        assign level_tab[c] = (RAW > b64su_pkg::LEVEL_MAX) ?
                              b64su_pkg::LEVEL_W'(b64su_pkg::LEVEL_MAX) :
                              b64su_pkg::LEVEL_W'(RAW);
    end

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == b64su_pkg::ADDR_MAX_SAMPLES);

    always_comb
    begin
        prdata = '0;
        if (paddr == b64su_pkg::ADDR_MAX_SAMPLES)
        begin
            prdata = b64su_pkg::DATA_W'(max_samples_reg);
        end
    end

    // decode sextet and extract byte
    always_comb
    begin
        sx        = b64su_pkg::sextet_decode(item_char_reg);
        acc       = {sextet_bits_reg[ACC_W-b64su_pkg::SEXTET_W-1:0], sx.value};
        cnt6      = sextet_count_reg + SCNT_W'(b64su_pkg::SEXTET_W);
        byte_ok   = sx.ok && (cnt6 >= SCNT_W'(b64su_pkg::BYTE_W));
        cnt_after = cnt6 - SCNT_W'(b64su_pkg::BYTE_W);
        acc_shift = acc >> cnt_after;
        byte_val  = acc_shift[b64su_pkg::BYTE_W-1:0];
        pool      = sample_bits_reg | (SB_W'(byte_val) << sample_count_reg);
        total     = sample_count_reg + SBC_W'(b64su_pkg::BYTE_W);
    end

    // unpack samples
    always_comb
    begin
        rest_bits = pool;
        rest_cnt  = total;
        n_emit    = '0;
        for (int k = 0; k < MAX_RES; k++)
        begin
            present[k]   = byte_ok && (total >= SBC_W'((k + 1) * SAMPLE_BITS));
            pos[k]       = GIVEN_W'(given_reg) + GIVEN_W'(k);
            emit[k]      = present[k] && (pos[k] < GIVEN_W'(max_samples_reg));
            new_code[k]  = pool[k*SAMPLE_BITS +: SAMPLE_BITS];
            new_index[k] = pos[k][LIMIT_WIDTH-1:0];
            if (present[k])
            begin
                rest_bits = pool >> ((k + 1) * SAMPLE_BITS);
                rest_cnt  = total - SBC_W'((k + 1) * SAMPLE_BITS);
            end
            if (emit[k])
            begin
                n_emit = n_emit + BANK_CW'(1);
            end
        end
        res_n = (item_end_reg && n_emit == '0) ? BANK_CW'(1) : n_emit;
    end

    assign out_valid = (bank_cnt_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign bank_free = (bank_cnt_reg == '0) || ((bank_cnt_reg == BANK_CW'(1)) && pop);
    assign fire      = item_valid_reg && ((res_n == '0) || bank_free);
    assign in_stall  = item_valid_reg && !fire;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (fire)
        begin
            item_valid_next = 1'b0;
        end
    end

    // advance stream state
    always_comb
    begin
        sextet_bits_next  = sextet_bits_reg;
        sextet_count_next = sextet_count_reg;
        sample_bits_next  = sample_bits_reg;
        sample_count_next = sample_count_reg;
        given_next        = given_reg;
        if (fire)
        begin
            if (item_end_reg)
            begin
                sextet_bits_next  = '0;
                sextet_count_next = '0;
                sample_bits_next  = '0;
                sample_count_next = '0;
                given_next        = '0;
            end
            else if (sx.ok)
            begin
                if (byte_ok)
                begin
                    sextet_bits_next  = acc & ~({ACC_W{1'b1}} << cnt_after);
                    sextet_count_next = cnt_after;
                    sample_bits_next  = rest_bits;
                    sample_count_next = rest_cnt;
                    given_next        = given_reg + LIMIT_WIDTH'(n_emit);
                end
                else
                begin
                    sextet_bits_next  = acc;
                    sextet_count_next = cnt6;
                end
            end
        end
    end

    // load or shift result bank
    always_comb
    begin
        bank_cnt_next = bank_cnt_reg;
        for (int k = 0; k < MAX_RES; k++)
        begin
            bank_code_next[k]  = bank_code_reg[k];
            bank_index_next[k] = bank_index_reg[k];
            bank_valid_next[k] = bank_valid_reg[k];
            bank_last_next[k]  = bank_last_reg[k];
        end
        if (fire && res_n != '0)
        begin
            bank_cnt_next = res_n;
            for (int k = 0; k < MAX_RES; k++)
            begin
                bank_code_next[k]  = new_code[k];
                bank_index_next[k] = new_index[k];
                bank_valid_next[k] = 1'b1;
                bank_last_next[k]  = item_end_reg && (n_emit == BANK_CW'(k + 1));
            end
            if (n_emit == '0)
            begin
                bank_code_next[0]  = '0;
                bank_index_next[0] = '0;
                bank_valid_next[0] = 1'b0;
                bank_last_next[0]  = 1'b1;
            end
        end
        else if (pop)
        begin
            bank_cnt_next = bank_cnt_reg - BANK_CW'(1);
            for (int k = 0; k < MAX_RES - 1; k++)
            begin
                bank_code_next[k]  = bank_code_reg[k+1];
                bank_index_next[k] = bank_index_reg[k+1];
                bank_valid_next[k] = bank_valid_reg[k+1];
                bank_last_next[k]  = bank_last_reg[k+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_samples_reg  <= LIMIT_WIDTH'(b64su_pkg::MAX_SAMPLES_RESET);
            item_valid_reg   <= 1'b0;
            sextet_bits_reg  <= '0;
            sextet_count_reg <= '0;
            sample_bits_reg  <= '0;
            sample_count_reg <= '0;
            given_reg        <= '0;
            bank_cnt_reg     <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                max_samples_reg <= pwdata[LIMIT_WIDTH-1:0];
            end
            item_valid_reg   <= item_valid_next;
            sextet_bits_reg  <= sextet_bits_next;
            sextet_count_reg <= sextet_count_next;
            sample_bits_reg  <= sample_bits_next;
            sample_count_reg <= sample_count_next;
            given_reg        <= given_next;
            bank_cnt_reg     <= bank_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_char_reg <= text_char;
            item_end_reg  <= end_of_text;
        end
        for (int k = 0; k < MAX_RES; k++)
        begin
            bank_code_reg[k]  <= bank_code_next[k];
            bank_index_reg[k] <= bank_index_next[k];
            bank_valid_reg[k] <= bank_valid_next[k];
            bank_last_reg[k]  <= bank_last_next[k];
        end
    end

    assign sample_code  = bank_code_reg[0];
    assign sample_level = level_tab[bank_code_reg[0]];
    assign sample_index = bank_index_reg[0];
    assign sample_valid = bank_valid_reg[0];
    assign last_result  = bank_last_reg[0];

endmodule

`default_nettype wire
